>>> design/eased_orientation_interpolator_top_defines.svh
// Assertion macros used by the datapath of the eased orientation interpolator.
`ifndef EASED_ORIENTATION_INTERPOLATOR_TOP_DEFINES_SVH
`define EASED_ORIENTATION_INTERPOLATOR_TOP_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define EOI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another one in the same cycle.
`define EOI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another one in the next cycle.
`define EOI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/eoi_pkg.sv
// Package of the eased orientation interpolator: constants, command codes, types and sine table.
package eoi_pkg;

    localparam int WORD_W             = 32;
    localparam int FRAC_BITS          = 16;
    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int ONE_W              = FRAC_BITS + 1;
    localparam int DVD_W              = WORD_W + FRAC_BITS;
    localparam int IDX_BITS           = $clog2(SINE_TABLE_ENTRIES);
    localparam int TAB_IDX_W          = IDX_BITS + 1;
    localparam int AXES               = 3;
    localparam int AXIS_W             = 2;
    localparam int CFG_IDX_W          = 3;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [ONE_W-1:0]  ONE_FX      = ONE_W'(1) << FRAC_BITS;
    localparam logic [WORD_W-1:0] DURATION_RST = WORD_W'(1) << FRAC_BITS;
    localparam logic [AXIS_W-1:0] LAST_AXIS   = AXIS_W'(AXES - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EASE_IN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EASE_OUT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Z   = 3'd5;

    // Datapath commands.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD        = 5'd1;
    localparam logic [OP_W-1:0] OP_BEGIN_JUMP  = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV_IN      = 5'd3;
    localparam logic [OP_W-1:0] OP_SET_IN      = 5'd4;
    localparam logic [OP_W-1:0] OP_DIV_OUT     = 5'd5;
    localparam logic [OP_W-1:0] OP_SET_OUT     = 5'd6;
    localparam logic [OP_W-1:0] OP_TICK_JUMP   = 5'd7;
    localparam logic [OP_W-1:0] OP_DIV_STEP    = 5'd8;
    localparam logic [OP_W-1:0] OP_ADVANCE     = 5'd9;
    localparam logic [OP_W-1:0] OP_ARG_IN_ONE  = 5'd10;
    localparam logic [OP_W-1:0] OP_ARG_OUT_ONE = 5'd11;
    localparam logic [OP_W-1:0] OP_DIV_ARG_IN  = 5'd12;
    localparam logic [OP_W-1:0] OP_DIV_ARG_OUT = 5'd13;
    localparam logic [OP_W-1:0] OP_SET_ARG     = 5'd14;
    localparam logic [OP_W-1:0] OP_SINE_MUL    = 5'd15;
    localparam logic [OP_W-1:0] OP_SINE_SUM    = 5'd16;
    localparam logic [OP_W-1:0] OP_EASE_MUL    = 5'd17;
    localparam logic [OP_W-1:0] OP_EASE_SUM    = 5'd18;
    localparam logic [OP_W-1:0] OP_LINEAR      = 5'd19;
    localparam logic [OP_W-1:0] OP_LERP_MUL    = 5'd20;
    localparam logic [OP_W-1:0] OP_LERP_SUM    = 5'd21;
    localparam logic [OP_W-1:0] OP_OUT         = 5'd22;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [AXIS_W-1:0] axis;
    } eoi_cmd_t;

    typedef struct packed {
        logic func;
        logic dur_zero;
        logic div_done;
        logic in_win;
        logic out_win;
        logic in_ratio_zero;
        logic out_ratio_zero;
        logic out_free;
    } eoi_stat_t;

    typedef logic [ONE_W-1:0] qsine_tab_t [0:SINE_TABLE_ENTRIES];

    // Shift and subtract quotient, used only while the table is built.
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quarter sine over [0, pi/2], Taylor series in Q2.30, rounded to FRAC_BITS.
    function automatic qsine_tab_t build_qsine();
        qsine_tab_t       tab;
        longint unsigned  a;
        longint unsigned  term;
        longint unsigned  r;
        longint           sum;
        for (int i = 0; i <= SINE_TABLE_ENTRIES; i++)
        begin
            a    = (HALF_PI_Q30 * longint'(i)) >> IDX_BITS;
            term = a;
            sum  = longint'(a);
            for (int k = 1; k <= 6; k++)
            begin
                term = (term * a) >> 30;
                term = (term * a) >> 30;
                term = div_u64(term, longint'((2 * k) * (2 * k + 1)));
                if ((k & 1) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            r = (longint'(sum) + (longint'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            if (r > (longint'(1) << FRAC_BITS))
                r = longint'(1) << FRAC_BITS;
            tab[i] = r[ONE_W-1:0];
        end
        return tab;
    endfunction

    localparam qsine_tab_t QSINE = build_qsine();

endpackage

>>> design/eoi_div.sv
// Restoring divider that produces one quotient bit per cycle.
module eoi_div
    import eoi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic [DVD_W-1:0]  quotient,
    output logic              done
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DVD_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dsr_reg;
    logic [WORD_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? WORD_W'(trial - {1'b0, dsr_reg}) : trial[WORD_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
        end
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;

endmodule

>>> design/eoi_dp.sv
// Datapath of the interpolator: configuration, move state, shared divider and multipliers.
module eoi_dp
    import eoi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_wdata,
    input  logic                     func,
    input  logic [WORD_W-1:0]        delta_time,
    input  logic signed [WORD_W-1:0] origin_x,
    input  logic signed [WORD_W-1:0] origin_y,
    input  logic signed [WORD_W-1:0] origin_z,
    input  logic                     out_stall,
    input  eoi_cmd_t                 cmd,
    output eoi_stat_t                stat,
    output logic                     out_valid,
    output logic signed [WORD_W-1:0] angle_x,
    output logic signed [WORD_W-1:0] angle_y,
    output logic signed [WORD_W-1:0] angle_z,
    output logic [ONE_W-1:0]         blend,
    output logic                     finished
);

    `include "eased_orientation_interpolator_top_defines.svh"

    localparam int LERP_W = WORD_W + 1 + ONE_W + 1;
    localparam int EMUL_W = 2 * ONE_W;

    // Configuration.
    logic [WORD_W-1:0] duration_reg;
    logic [WORD_W-1:0] ease_in_reg;
    logic [WORD_W-1:0] ease_out_reg;
    logic [WORD_W-1:0] goal_reg [0:AXES-1];

    // Move state.
    logic [WORD_W-1:0] start_reg [0:AXES-1];
    logic [WORD_W-1:0] progress_reg;
    logic [ONE_W-1:0]  in_ratio_reg;
    logic [ONE_W-1:0]  out_ratio_reg;
    logic [ONE_W-1:0]  out_begin_reg;

    // Per-item scratch.
    logic              func_reg;
    logic [WORD_W-1:0] dt_reg;
    logic              mode_in_reg;
    logic [ONE_W-1:0]  arg_reg;
    logic [ONE_W-1:0]  t0_reg;
    logic              sfull_reg;
    logic [EMUL_W-1:0] mul_reg;
    logic [ONE_W-1:0]  qs_reg;
    logic [ONE_W-1:0]  blend_reg;
    logic signed [LERP_W-1:0] prod_reg;
    logic [WORD_W-1:0] ang_reg [0:AXES-1];

    // Output register.
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_ang_reg [0:AXES-1];
    logic [ONE_W-1:0]  out_blend_reg;
    logic              out_fin_reg;

    // Divider hookup.
    logic              div_start;
    logic [DVD_W-1:0]  div_dvd;
    logic [WORD_W-1:0] div_dsr;
    logic [DVD_W-1:0]  div_quo;
    logic              div_done;
    logic [ONE_W-1:0]  quo_sat;
    logic [WORD_W-1:0] prog_rel;
    logic [DVD_W:0]    prog_sum;

    // Sine lookup.
    logic [ONE_W-1:0]     sx;
    logic [IDX_BITS-1:0]  sidx;
    logic [FRAC_BITS-1:0] sfrac;
    logic [ONE_W-1:0]     t0;
    logic [ONE_W-1:0]     t1;
    logic [ONE_W-1:0]     t1c;

    // Ease and lerp.
    logic [ONE_W-1:0]  ease_e;
    logic [ONE_W-1:0]  ease_r;
    logic [ONE_W:0]    ease_v;
    logic signed [WORD_W:0] lerp_d;
    logic              out_take;

    eoi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign prog_rel = progress_reg - WORD_W'(out_begin_reg);
    assign quo_sat  = (div_quo > DVD_W'(ONE_FX)) ? ONE_FX : div_quo[ONE_W-1:0];
    assign prog_sum = (DVD_W + 1)'(progress_reg) + (DVD_W + 1)'(div_quo);

    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = {dt_reg, FRAC_BITS'(0)};
        div_dsr   = duration_reg;
        case (cmd.op)
            OP_DIV_IN:
            begin
                div_start = 1'b1;
                div_dvd   = {ease_in_reg, FRAC_BITS'(0)};
            end
            OP_DIV_OUT:
            begin
                div_start = 1'b1;
                div_dvd   = {ease_out_reg, FRAC_BITS'(0)};
            end
            OP_DIV_STEP:
            begin
                div_start = 1'b1;
            end
            OP_DIV_ARG_IN:
            begin
                div_start = 1'b1;
                div_dvd   = {progress_reg, FRAC_BITS'(0)};
                div_dsr   = WORD_W'(in_ratio_reg);
            end
            OP_DIV_ARG_OUT:
            begin
                div_start = 1'b1;
                div_dvd   = {prog_rel, FRAC_BITS'(0)};
                div_dsr   = WORD_W'(out_ratio_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // Cosine is read as sine of the complement.
    assign sx    = mode_in_reg ? ONE_FX - arg_reg : arg_reg;
    assign sidx  = sx[FRAC_BITS-1 -: IDX_BITS];
    assign sfrac = FRAC_BITS'(sx[FRAC_BITS-IDX_BITS-1:0]) << IDX_BITS;
    assign t0    = QSINE[{1'b0, sidx}];
    assign t1    = QSINE[TAB_IDX_W'({1'b0, sidx}) + TAB_IDX_W'(1)];
    assign t1c   = (t1 < t0) ? t0 : t1;

    assign ease_e = mode_in_reg ? ONE_FX - qs_reg : qs_reg;
    assign ease_r = mode_in_reg ? in_ratio_reg : out_ratio_reg;
    assign ease_v = mode_in_reg ? (ONE_W + 1)'(mul_reg[EMUL_W-1:FRAC_BITS])
                  : (ONE_W + 1)'(out_begin_reg) + (ONE_W + 1)'(mul_reg[EMUL_W-1:FRAC_BITS]);

    assign lerp_d = $signed({goal_reg[cmd.axis][WORD_W-1], goal_reg[cmd.axis]})
                  - $signed({start_reg[cmd.axis][WORD_W-1], start_reg[cmd.axis]});

    assign out_take = out_valid_reg && !out_stall;

    // Architectural state with reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg  <= DURATION_RST;
            ease_in_reg   <= '0;
            ease_out_reg  <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                goal_reg[i]  <= '0;
                start_reg[i] <= '0;
            end
            progress_reg  <= '0;
            in_ratio_reg  <= '0;
            out_ratio_reg <= '0;
            out_begin_reg <= ONE_FX;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_DURATION: duration_reg <= cfg_wdata;
                    REG_EASE_IN:  ease_in_reg  <= cfg_wdata;
                    REG_EASE_OUT: ease_out_reg <= cfg_wdata;
                    REG_GOAL_X:   goal_reg[0]  <= cfg_wdata;
                    REG_GOAL_Y:   goal_reg[1]  <= cfg_wdata;
                    REG_GOAL_Z:   goal_reg[2]  <= cfg_wdata;
                    default:      duration_reg <= duration_reg;
                endcase
            end

            if (cmd.op == OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;

            case (cmd.op)
                OP_LOAD:
                begin
                    if (!func)
                    begin
                        start_reg[0] <= origin_x;
                        start_reg[1] <= origin_y;
                        start_reg[2] <= origin_z;
                    end
                end
                OP_BEGIN_JUMP:
                begin
                    in_ratio_reg  <= ONE_FX;
                    out_ratio_reg <= ONE_FX;
                    out_begin_reg <= '0;
                    progress_reg  <= '0;
                end
                OP_SET_IN:
                begin
                    in_ratio_reg <= quo_sat;
                end
                OP_SET_OUT:
                begin
                    out_ratio_reg <= quo_sat;
                    out_begin_reg <= ONE_FX - quo_sat;
                    progress_reg  <= '0;
                end
                OP_TICK_JUMP:
                begin
                    progress_reg <= WORD_W'(ONE_FX);
                end
                OP_ADVANCE:
                begin
                    progress_reg <= (prog_sum > (DVD_W + 1)'({WORD_W{1'b1}}))
                                  ? {WORD_W{1'b1}} : prog_sum[WORD_W-1:0];
                end
                default:
                begin
                    progress_reg <= progress_reg;
                end
            endcase
        end
    end

    // Scratch registers that need no reset.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg <= func;
                dt_reg   <= delta_time;
            end
            OP_TICK_JUMP:
            begin
                blend_reg <= ONE_FX;
            end
            OP_ARG_IN_ONE:
            begin
                mode_in_reg <= 1'b1;
                arg_reg     <= ONE_FX;
            end
            OP_ARG_OUT_ONE:
            begin
                mode_in_reg <= 1'b0;
                arg_reg     <= ONE_FX;
            end
            OP_DIV_ARG_IN:
            begin
                mode_in_reg <= 1'b1;
            end
            OP_DIV_ARG_OUT:
            begin
                mode_in_reg <= 1'b0;
            end
            OP_SET_ARG:
            begin
                arg_reg <= quo_sat;
            end
            OP_SINE_MUL:
            begin
                sfull_reg <= sx[FRAC_BITS];
                t0_reg    <= sx[FRAC_BITS] ? QSINE[SINE_TABLE_ENTRIES] : t0;
                mul_reg   <= EMUL_W'(t1c - t0) * EMUL_W'(sfrac);
            end
            OP_SINE_SUM:
            begin
                qs_reg <= sfull_reg ? t0_reg
                        : t0_reg + ONE_W'(mul_reg[EMUL_W-1:FRAC_BITS]);
            end
            OP_EASE_MUL:
            begin
                mul_reg <= ease_e * ease_r;
            end
            OP_EASE_SUM:
            begin
                blend_reg <= (ease_v > (ONE_W + 1)'(ONE_FX)) ? ONE_FX : ease_v[ONE_W-1:0];
            end
            OP_LINEAR:
            begin
                blend_reg <= (progress_reg > WORD_W'(ONE_FX)) ? ONE_FX
                           : progress_reg[ONE_W-1:0];
            end
            OP_LERP_MUL:
            begin
                prod_reg <= lerp_d * $signed({1'b0, blend_reg});
            end
            OP_LERP_SUM:
            begin
                ang_reg[cmd.axis] <= start_reg[cmd.axis] + prod_reg[FRAC_BITS +: WORD_W];
            end
            OP_OUT:
            begin
                for (int i = 0; i < AXES; i++)
                    out_ang_reg[i] <= ang_reg[i];
                out_blend_reg <= blend_reg;
                out_fin_reg   <= progress_reg >= WORD_W'(ONE_FX);
            end
            default:
            begin
                dt_reg <= dt_reg;
            end
        endcase
    end

    assign stat.func           = func_reg;
    assign stat.dur_zero       = duration_reg == '0;
    assign stat.div_done       = div_done;
    assign stat.in_win         = (ease_in_reg != '0) && (progress_reg <= WORD_W'(in_ratio_reg));
    assign stat.out_win        = (ease_out_reg != '0) && (progress_reg >= WORD_W'(out_begin_reg));
    assign stat.in_ratio_zero  = in_ratio_reg == '0;
    assign stat.out_ratio_zero = out_ratio_reg == '0;
    assign stat.out_free       = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign angle_x   = out_ang_reg[0];
    assign angle_y   = out_ang_reg[1];
    assign angle_z   = out_ang_reg[2];
    assign blend     = out_blend_reg;
    assign finished  = out_fin_reg;

    `EOI_ASSERT_ALWAYS(a_ratio_range, (in_ratio_reg <= ONE_FX) && (out_ratio_reg <= ONE_FX), "ease ratio above one")
    `EOI_ASSERT_IMPLY(a_div_nonzero, div_start, div_dsr != '0, "divider started with a zero divisor")
    `EOI_ASSERT_NEXT(a_out_blend_range, cmd.op == OP_OUT, out_blend_reg <= ONE_FX, "blend word above one")
    `EOI_ASSERT_IMPLY(a_out_no_overwrite, cmd.op == OP_OUT, !out_valid_reg || !out_stall, "result word overwritten while stalled")

endmodule

>>> design/eoi_ctrl.sv
// Controller state machine that sequences the datapath for begin and tick words.
module eoi_ctrl
    import eoi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  eoi_stat_t stat,
    output eoi_cmd_t  cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] S_DECODE    = 4'd1;
    localparam logic [ST_W-1:0] S_WAIT_IN   = 4'd2;
    localparam logic [ST_W-1:0] S_BEGIN_OUT = 4'd3;
    localparam logic [ST_W-1:0] S_WAIT_OUT  = 4'd4;
    localparam logic [ST_W-1:0] S_WAIT_STEP = 4'd5;
    localparam logic [ST_W-1:0] S_REGION    = 4'd6;
    localparam logic [ST_W-1:0] S_WAIT_ARG  = 4'd7;
    localparam logic [ST_W-1:0] S_SINE_MUL  = 4'd8;
    localparam logic [ST_W-1:0] S_SINE_SUM  = 4'd9;
    localparam logic [ST_W-1:0] S_EASE_MUL  = 4'd10;
    localparam logic [ST_W-1:0] S_EASE_SUM  = 4'd11;
    localparam logic [ST_W-1:0] S_LERP_MUL  = 4'd12;
    localparam logic [ST_W-1:0] S_LERP_SUM  = 4'd13;
    localparam logic [ST_W-1:0] S_OUT       = 4'd14;

    logic [ST_W-1:0]   state_reg;
    logic [ST_W-1:0]   state_next;
    logic [AXIS_W-1:0] axis_reg;
    logic [AXIS_W-1:0] axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        cmd.op     = OP_NONE;
        cmd.axis   = axis_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                axis_next = '0;
                if (!stat.func)
                begin
                    if (stat.dur_zero)
                    begin
                        cmd.op     = OP_BEGIN_JUMP;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.op     = OP_DIV_IN;
                        state_next = S_WAIT_IN;
                    end
                end
                else if (stat.dur_zero)
                begin
                    cmd.op     = OP_TICK_JUMP;
                    state_next = S_LERP_MUL;
                end
                else
                begin
                    cmd.op     = OP_DIV_STEP;
                    state_next = S_WAIT_STEP;
                end
            end
            S_WAIT_IN:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_SET_IN;
                    state_next = S_BEGIN_OUT;
                end
            end
            S_BEGIN_OUT:
            begin
                cmd.op     = OP_DIV_OUT;
                state_next = S_WAIT_OUT;
            end
            S_WAIT_OUT:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_SET_OUT;
                    state_next = S_IDLE;
                end
            end
            S_WAIT_STEP:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_ADVANCE;
                    state_next = S_REGION;
                end
            end
            S_REGION:
            begin
                if (stat.in_win)
                begin
                    cmd.op     = stat.in_ratio_zero ? OP_ARG_IN_ONE : OP_DIV_ARG_IN;
                    state_next = stat.in_ratio_zero ? S_SINE_MUL : S_WAIT_ARG;
                end
                else if (stat.out_win)
                begin
                    cmd.op     = stat.out_ratio_zero ? OP_ARG_OUT_ONE : OP_DIV_ARG_OUT;
                    state_next = stat.out_ratio_zero ? S_SINE_MUL : S_WAIT_ARG;
                end
                else
                begin
                    cmd.op     = OP_LINEAR;
                    state_next = S_LERP_MUL;
                end
            end
            S_WAIT_ARG:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_SET_ARG;
                    state_next = S_SINE_MUL;
                end
            end
            S_SINE_MUL:
            begin
                cmd.op     = OP_SINE_MUL;
                state_next = S_SINE_SUM;
            end
            S_SINE_SUM:
            begin
                cmd.op     = OP_SINE_SUM;
                state_next = S_EASE_MUL;
            end
            S_EASE_MUL:
            begin
                cmd.op     = OP_EASE_MUL;
                state_next = S_EASE_SUM;
            end
            S_EASE_SUM:
            begin
                cmd.op     = OP_EASE_SUM;
                state_next = S_LERP_MUL;
            end
            S_LERP_MUL:
            begin
                cmd.op     = OP_LERP_MUL;
                state_next = S_LERP_SUM;
            end
            S_LERP_SUM:
            begin
                cmd.op = OP_LERP_SUM;
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_LERP_MUL;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

>>> design/eased_orientation_interpolator_top.sv
// Top level of the eased orientation interpolator: controller plus datapath.
//
//   Channel   Direction  Handshake            Payload
//   input     in         in_valid / in_stall  func, delta_time, origin_x/y/z
//   result    out        out_valid/out_stall  angle_x/y/z, blend, finished
//   config    in         cfg_wr_en            cfg_index, cfg_wdata
//
// One word is worked on at a time. A begin word with a nonzero duration runs two ratio
// divisions, and with a zero duration none; it gives no result.
// A tick word with a nonzero duration runs one step division; inside an ease window it
// adds one more for the curve argument (unless the ratio is zero), the sine lookup and
// the ease; then three shared lerp multiplies. With a zero duration only the lerp runs.
// The shared divider retires one quotient bit per cycle over a 48-bit dividend. The
// result sits in an output register, so a stalled result only holds the block once
// the next tick is ready to replace it.
// Reset is asynchronous and active low; it restores the configuration and move state.
module eased_orientation_interpolator_top
    import eoi_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     func,
    input  logic [WORD_W-1:0]        delta_time,
    input  logic signed [WORD_W-1:0] origin_x,
    input  logic signed [WORD_W-1:0] origin_y,
    input  logic signed [WORD_W-1:0] origin_z,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] angle_x,
    output logic signed [WORD_W-1:0] angle_y,
    output logic signed [WORD_W-1:0] angle_z,
    output logic [ONE_W-1:0]         blend,
    output logic                     finished
);

    // Commands flow from the controller; status flows back from the datapath.
    eoi_cmd_t  cmd;
    eoi_stat_t stat;

    eoi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the configuration and move registers, the divider and the result word.
    eoi_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .func       (func),
        .delta_time (delta_time),
        .origin_x   (origin_x),
        .origin_y   (origin_y),
        .origin_z   (origin_z),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .angle_x    (angle_x),
        .angle_y    (angle_y),
        .angle_z    (angle_z),
        .blend      (blend),
        .finished   (finished)
    );

endmodule
